// ===== rtl/pidaw_pkg.sv =====
package pidaw_pkg;

	localparam int DATA_W  = 32;
	localparam int DT_W    = 24;
	localparam int ACC_W   = 48;
	localparam int GAIN_W  = 31;
	localparam int ALPHA_W = 17;
	localparam int OUT_W   = 18;
	localparam int FRAC    = 16;
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int PROD_W  = 62;
	localparam int DIV_N_W = 56;
	localparam int DIV_D_W = 32;
	localparam int SUM_W   = 64;
	localparam int WIDE_W  = DIV_N_W + 2;

	localparam logic [ALPHA_W-1:0] ONE      = 17'd65536;
	localparam logic [DIV_D_W-1:0] US_PER_S = 32'd1000000;
	localparam logic [DIV_N_W-1:0] HALF_US  = 56'd500000;
	localparam logic [PROD_W-1:0]  PROD_LIM = 62'h2000_0000_0000_0000;
	localparam logic signed [WIDE_W-1:0] ACC_HI = (58'sd1 <<< 47) - 58'sd1;
	localparam logic signed [WIDE_W-1:0] ACC_LO = -(58'sd1 <<< 47);

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_INT_MIN,
		REG_INT_MAX,
		REG_ALPHA
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INT_MUL,
		ST_INT_DIV,
		ST_RAW_MUL,
		ST_RAW_DIV,
		ST_LO_DIV,
		ST_HI_DIV,
		ST_DA_MUL,
		ST_DB_MUL,
		ST_CP_MUL,
		ST_CI_MUL,
		ST_CD_MUL,
		ST_OUT
	} state_t;

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > ACC_HI) begin
			r = ACC_HI[ACC_W-1:0];
		end else if (v < ACC_LO) begin
			r = ACC_LO[ACC_W-1:0];
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [WIDE_W-1:0] signed_of(input logic [DIV_N_W-1:0] m,
			input logic neg);
		logic signed [WIDE_W-1:0] w;
		w = signed'({2'b00, m});
		return neg ? -w : w;
	endfunction

	function automatic logic [ACC_W-1:0] mag_of(input logic signed [ACC_W-1:0] v);
		return v[ACC_W-1] ? ACC_W'(-v) : v;
	endfunction

	function automatic logic signed [SUM_W-1:0] with_sign(input logic [PROD_W-1:0] p,
			input logic neg);
		logic signed [SUM_W-1:0] w;
		w = signed'({2'b00, p});
		return neg ? -w : w;
	endfunction

	// Magnitude of v / 2^16, rounded to nearest with ties away from zero.
	function automatic logic [ACC_W-1:0] round_frac(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-1:0] m;
		logic [SUM_W-1:0] s;
		m = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
		s = m + 64'd32768;
		return s[SUM_W-1:FRAC];
	endfunction

endpackage

// ===== rtl/pid_with_antiwindup_filtered_d.sv =====
// Channel   Direction  Handshake              Payload
// in        receive    in_valid / in_stall    error_in, elapsed_us
// out       send       out_valid / out_stall  drive, drive_clamped
// config    APB        psel/penable/pready    paddr, pwdata, prdata
//
// A result is loaded into the output register once its item's products and quotients are done, and
// the next item can be accepted in the cycle after that; items are not overlapped. Each of the seven
// products comes from the shared bit-serial multiplier, and each of the four quotients from the
// restoring divider; the two bound quotients are skipped with zero gain.
// Reset clears the controller history and loads the register defaults.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled result holds the block in its last step until taken.
module pid_with_antiwindup_filtered_d (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pidaw_pkg::DATA_W-1:0] error_in,
	input  logic [pidaw_pkg::DT_W-1:0]          elapsed_us,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pidaw_pkg::OUT_W-1:0]  drive,
	output logic                                drive_clamped,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [4:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	pidaw_pkg::state_t state_q, state_d;

	logic [pidaw_pkg::GAIN_W-1:0]        gain_p_q, gain_i_q, gain_d_q;
	logic signed [31:0]                  int_min_q, int_max_q;
	logic [pidaw_pkg::ALPHA_W-1:0]       alpha_q;

	logic signed [pidaw_pkg::DATA_W-1:0] e_q, prev_e_q;
	logic [pidaw_pkg::DT_W-1:0]          dt_q;
	logic signed [pidaw_pkg::ACC_W-1:0]  integ_q, prev_d_q, raw_q, lo_q;
	logic signed [pidaw_pkg::SUM_W-1:0]  dsum_q, csum_q;
	logic                                diff_neg_q;
	logic                                go_q;
	logic                                out_valid_q;
	logic signed [pidaw_pkg::OUT_W-1:0]  drive_q;
	logic                                clamped_q;

	logic                                is_mul, is_div, unit_done, load_out;
	logic                                mul_start, mul_done, div_start, div_done;
	logic [pidaw_pkg::MUL_A_W-1:0]       mul_a;
	logic [pidaw_pkg::MUL_B_W-1:0]       mul_b;
	logic [pidaw_pkg::PROD_W-1:0]        mul_prod;
	logic [pidaw_pkg::DIV_N_W-1:0]       div_num, div_quot;
	logic [pidaw_pkg::DIV_D_W-1:0]       div_den;

	logic signed [32:0]                  diff;
	logic [pidaw_pkg::ALPHA_W-1:0]       alpha_eff;
	logic [31:0]                         min_mag, max_mag;
	logic signed [pidaw_pkg::ACC_W-1:0]  q_hi, q_deriv;
	logic signed [pidaw_pkg::SUM_W-1:0]  d_total;
	logic [pidaw_pkg::ACC_W-1:0]         cmd_mag;
	logic [pidaw_pkg::OUT_W-1:0]         drv_mag;
	logic                                cfg_wr;

	assign diff      = {e_q[31], e_q} - {prev_e_q[31], prev_e_q};
	assign alpha_eff = (alpha_q > pidaw_pkg::ONE) ? pidaw_pkg::ONE : alpha_q;
	assign min_mag   = 32'(pidaw_pkg::mag_of({{16{int_min_q[31]}}, int_min_q}));
	assign max_mag   = 32'(pidaw_pkg::mag_of({{16{int_max_q[31]}}, int_max_q}));
	assign q_hi      = pidaw_pkg::sat_acc(pidaw_pkg::signed_of(div_quot, int_max_q[31]));
	assign d_total   = dsum_q + pidaw_pkg::with_sign(mul_prod, prev_d_q[pidaw_pkg::ACC_W-1]);
	assign q_deriv   = d_total[pidaw_pkg::SUM_W-1]
			? -signed'(pidaw_pkg::round_frac(d_total))
			: signed'(pidaw_pkg::round_frac(d_total));
	assign cmd_mag   = pidaw_pkg::round_frac(csum_q);
	assign drv_mag   = (cmd_mag > {31'd0, pidaw_pkg::ONE}) ? {1'b0, pidaw_pkg::ONE}
			: cmd_mag[pidaw_pkg::OUT_W-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pidaw_pkg::ST_IDLE:    if (in_valid) state_d = pidaw_pkg::ST_INT_MUL;
			pidaw_pkg::ST_INT_MUL: if (unit_done) state_d = pidaw_pkg::ST_INT_DIV;
			pidaw_pkg::ST_INT_DIV: if (unit_done) state_d = pidaw_pkg::ST_RAW_MUL;
			pidaw_pkg::ST_RAW_MUL: if (unit_done) state_d = pidaw_pkg::ST_RAW_DIV;
			pidaw_pkg::ST_RAW_DIV: begin
				if (unit_done) begin
					state_d = (gain_i_q != '0) ? pidaw_pkg::ST_LO_DIV : pidaw_pkg::ST_DA_MUL;
				end
			end
			pidaw_pkg::ST_LO_DIV:  if (unit_done) state_d = pidaw_pkg::ST_HI_DIV;
			pidaw_pkg::ST_HI_DIV:  if (unit_done) state_d = pidaw_pkg::ST_DA_MUL;
			pidaw_pkg::ST_DA_MUL:  if (unit_done) state_d = pidaw_pkg::ST_DB_MUL;
			pidaw_pkg::ST_DB_MUL:  if (unit_done) state_d = pidaw_pkg::ST_CP_MUL;
			pidaw_pkg::ST_CP_MUL:  if (unit_done) state_d = pidaw_pkg::ST_CI_MUL;
			pidaw_pkg::ST_CI_MUL:  if (unit_done) state_d = pidaw_pkg::ST_CD_MUL;
			pidaw_pkg::ST_CD_MUL:  if (unit_done) state_d = pidaw_pkg::ST_OUT;
			pidaw_pkg::ST_OUT:     if (load_out) state_d = pidaw_pkg::ST_IDLE;
			default:               state_d = pidaw_pkg::ST_IDLE;
		endcase
	end

	// Unit selection and operands.
	always_comb begin
		is_mul  = 1'b0;
		is_div  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_num = '0;
		div_den = pidaw_pkg::US_PER_S;
		unique case (state_q)
			pidaw_pkg::ST_INT_MUL: begin
				is_mul = 1'b1;
				mul_a  = pidaw_pkg::mag_of({{16{e_q[31]}}, e_q});
				mul_b  = {8'd0, dt_q};
			end
			pidaw_pkg::ST_INT_DIV: begin
				is_div  = 1'b1;
				div_num = mul_prod[pidaw_pkg::DIV_N_W-1:0] + pidaw_pkg::HALF_US;
			end
			pidaw_pkg::ST_RAW_MUL: begin
				is_mul = 1'b1;
				mul_a  = pidaw_pkg::mag_of({{15{diff[32]}}, diff});
				mul_b  = pidaw_pkg::US_PER_S;
			end
			pidaw_pkg::ST_RAW_DIV: begin
				is_div  = 1'b1;
				div_num = mul_prod[pidaw_pkg::DIV_N_W-1:0] + {33'd0, dt_q[pidaw_pkg::DT_W-1:1]};
				div_den = {8'd0, dt_q};
			end
			pidaw_pkg::ST_LO_DIV: begin
				is_div  = 1'b1;
				div_num = {8'd0, min_mag, 16'd0} + {26'd0, gain_i_q[pidaw_pkg::GAIN_W-1:1]};
				div_den = {1'b0, gain_i_q};
			end
			pidaw_pkg::ST_HI_DIV: begin
				is_div  = 1'b1;
				div_num = {8'd0, max_mag, 16'd0} + {26'd0, gain_i_q[pidaw_pkg::GAIN_W-1:1]};
				div_den = {1'b0, gain_i_q};
			end
			pidaw_pkg::ST_DA_MUL: begin
				is_mul = 1'b1;
				mul_a  = pidaw_pkg::mag_of(raw_q);
				mul_b  = {15'd0, alpha_eff};
			end
			pidaw_pkg::ST_DB_MUL: begin
				is_mul = 1'b1;
				mul_a  = pidaw_pkg::mag_of(prev_d_q);
				mul_b  = {15'd0, pidaw_pkg::ONE - alpha_eff};
			end
			pidaw_pkg::ST_CP_MUL: begin
				is_mul = 1'b1;
				mul_a  = pidaw_pkg::mag_of({{16{e_q[31]}}, e_q});
				mul_b  = {1'b0, gain_p_q};
			end
			pidaw_pkg::ST_CI_MUL: begin
				is_mul = 1'b1;
				mul_a  = pidaw_pkg::mag_of(integ_q);
				mul_b  = {1'b0, gain_i_q};
			end
			pidaw_pkg::ST_CD_MUL: begin
				is_mul = 1'b1;
				mul_a  = pidaw_pkg::mag_of(prev_d_q);
				mul_b  = {1'b0, gain_d_q};
			end
			default: begin
			end
		endcase
	end

	assign mul_start = is_mul && !go_q;
	assign div_start = is_div && !go_q;
	assign unit_done = (is_mul && mul_done) || (is_div && div_done);
	assign load_out  = (state_q == pidaw_pkg::ST_OUT) && (!out_valid_q || !out_stall);

	pidaw_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pidaw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pidaw_pkg::ST_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
			prev_e_q    <= '0;
			integ_q     <= '0;
			prev_d_q    <= '0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start) begin
				go_q <= 1'b1;
			end else if (unit_done) begin
				go_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (unit_done) begin
				case (state_q)
					pidaw_pkg::ST_INT_DIV: begin
						integ_q <= pidaw_pkg::sat_acc({{10{integ_q[47]}}, integ_q}
								+ pidaw_pkg::signed_of(div_quot, e_q[31]));
					end
					pidaw_pkg::ST_RAW_MUL: prev_e_q <= e_q;
					pidaw_pkg::ST_HI_DIV: begin
						// The low bound wins when the bounds cross.
						if (integ_q < lo_q) begin
							integ_q <= lo_q;
						end else if (integ_q > q_hi) begin
							integ_q <= q_hi;
						end
					end
					pidaw_pkg::ST_DB_MUL: prev_d_q <= q_deriv;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pidaw_pkg::ST_IDLE && in_valid) begin
			e_q  <= error_in;
			dt_q <= (elapsed_us == '0) ? pidaw_pkg::DT_W'(1) : elapsed_us;
		end
		if (unit_done) begin
			case (state_q)
				pidaw_pkg::ST_RAW_MUL: diff_neg_q <= diff[32];
				pidaw_pkg::ST_RAW_DIV: begin
					raw_q <= pidaw_pkg::sat_acc(pidaw_pkg::signed_of(div_quot, diff_neg_q));
				end
				pidaw_pkg::ST_LO_DIV: begin
					lo_q <= pidaw_pkg::sat_acc(pidaw_pkg::signed_of(div_quot, int_min_q[31]));
				end
				pidaw_pkg::ST_DA_MUL: dsum_q <= pidaw_pkg::with_sign(mul_prod, raw_q[47]);
				pidaw_pkg::ST_CP_MUL: csum_q <= pidaw_pkg::with_sign(mul_prod, e_q[31]);
				pidaw_pkg::ST_CI_MUL: csum_q <= csum_q + pidaw_pkg::with_sign(mul_prod, integ_q[47]);
				pidaw_pkg::ST_CD_MUL: csum_q <= csum_q + pidaw_pkg::with_sign(mul_prod, prev_d_q[47]);
				default: begin
				end
			endcase
		end
		if (load_out) begin
			drive_q   <= csum_q[pidaw_pkg::SUM_W-1] ? -signed'(drv_mag) : signed'(drv_mag);
			clamped_q <= cmd_mag > {31'd0, pidaw_pkg::ONE};
		end
	end

	// Configuration registers.
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= 31'd15073;
			gain_i_q  <= 31'd1966;
			gain_d_q  <= 31'd1311;
			int_min_q <= -32'sd3277;
			int_max_q <= 32'sd3277;
			alpha_q   <= 17'd65536;
		end else if (cfg_wr) begin
			unique case (pidaw_pkg::reg_idx_t'(paddr[4:2]))
				pidaw_pkg::REG_GAIN_P:  gain_p_q  <= pwdata[30:0];
				pidaw_pkg::REG_GAIN_I:  gain_i_q  <= pwdata[30:0];
				pidaw_pkg::REG_GAIN_D:  gain_d_q  <= pwdata[30:0];
				pidaw_pkg::REG_INT_MIN: int_min_q <= signed'(pwdata);
				pidaw_pkg::REG_INT_MAX: int_max_q <= signed'(pwdata);
				pidaw_pkg::REG_ALPHA:   alpha_q   <= pwdata[16:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (pidaw_pkg::reg_idx_t'(paddr[4:2]))
			pidaw_pkg::REG_GAIN_P:  prdata = {1'b0, gain_p_q};
			pidaw_pkg::REG_GAIN_I:  prdata = {1'b0, gain_i_q};
			pidaw_pkg::REG_GAIN_D:  prdata = {1'b0, gain_d_q};
			pidaw_pkg::REG_INT_MIN: prdata = int_min_q;
			pidaw_pkg::REG_INT_MAX: prdata = int_max_q;
			pidaw_pkg::REG_ALPHA:   prdata = {15'd0, alpha_q};
			default:                prdata = '0;
		endcase
	end

	assign pready        = 1'b1;
	assign in_stall      = state_q != pidaw_pkg::ST_IDLE;
	assign out_valid     = out_valid_q;
	assign drive         = drive_q;
	assign drive_clamped = clamped_q;

endmodule

// ===== rtl/pidaw_mul.sv =====
module pidaw_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pidaw_pkg::MUL_A_W-1:0]  a,
	input  logic [pidaw_pkg::MUL_B_W-1:0]  b,
	output logic                           done,
	output logic [pidaw_pkg::PROD_W-1:0]   prod
);

	logic [pidaw_pkg::MUL_P_W-1:0] a_q;
	logic [pidaw_pkg::MUL_P_W-1:0] acc_q;
	logic [pidaw_pkg::MUL_B_W-1:0] b_q;
	logic [4:0]                    cnt_q;
	logic                          busy_q;
	logic                          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One multiplier bit per cycle, least significant first.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= {{pidaw_pkg::MUL_B_W{1'b0}}, a};
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[pidaw_pkg::MUL_P_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[pidaw_pkg::MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = (acc_q > {18'd0, pidaw_pkg::PROD_LIM}) ? pidaw_pkg::PROD_LIM
			: acc_q[pidaw_pkg::PROD_W-1:0];

endmodule

// ===== rtl/pidaw_div.sv =====
module pidaw_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pidaw_pkg::DIV_N_W-1:0]  num,
	input  logic [pidaw_pkg::DIV_D_W-1:0]  den,
	output logic                           done,
	output logic [pidaw_pkg::DIV_N_W-1:0]  quot
);

	logic [pidaw_pkg::DIV_N_W-1:0] num_q;
	logic [pidaw_pkg::DIV_D_W-1:0] den_q;
	logic [pidaw_pkg::DIV_D_W-1:0] rem_q;
	logic [5:0]                    cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [pidaw_pkg::DIV_D_W:0]   trial;
	logic                          fits;

	assign trial = {rem_q, num_q[pidaw_pkg::DIV_N_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(pidaw_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division: the quotient bits shift in where the dividend leaves.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? pidaw_pkg::DIV_D_W'(trial - {1'b0, den_q})
					: trial[pidaw_pkg::DIV_D_W-1:0];
			num_q <= {num_q[pidaw_pkg::DIV_N_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== bench/pid_with_antiwindup_filtered_d_tb.sv =====
`timescale 1ns / 1ps

module pid_with_antiwindup_filtered_d_tb;

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam longint Q_ONE = 64'sd65536;
	localparam longint ACC_MAX = (64'sd1 <<< 47) - 64'sd1;
	localparam longint ACC_MIN = -(64'sd1 <<< 47);
	localparam longint MAG_LIM = 64'sd1 <<< 61;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [pidaw_pkg::DATA_W-1:0] error_in = '0;
	logic [pidaw_pkg::DT_W-1:0] elapsed_us = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [pidaw_pkg::OUT_W-1:0] drive;
	logic drive_clamped;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Controller copy: configuration and history.
	longint kp, ki, kd, imin, imax, alpha_w;
	longint last_err, integ, last_deriv;

	typedef struct packed {
		logic signed [pidaw_pkg::OUT_W-1:0] drv;
		logic clip;
	} command_t;
	command_t pending_cmds[$];

	int fail_count = 0;
	bit long_hold = 1'b0;

	pid_with_antiwindup_filtered_d u_dut (.*);

	always #4 clk = ~clk;

	function automatic longint abs_val(longint a);
		return a < 0 ? -a : a;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint q;
		q = (abs_val(num) + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint clip_mul(longint a, longint b);
		longint m, p;
		m = abs_val(a);
		if (b != 0 && m > MAG_LIM / b) begin
			p = MAG_LIM;
		end else begin
			p = m * b;
		end
		if (p > MAG_LIM) begin
			p = MAG_LIM;
		end
		return a < 0 ? -p : p;
	endfunction

	function automatic longint clip_acc(longint v);
		return v > ACC_MAX ? ACC_MAX : (v < ACC_MIN ? ACC_MIN : v);
	endfunction

	task automatic predict_command(input logic signed [pidaw_pkg::DATA_W-1:0] err,
			input logic [pidaw_pkg::DT_W-1:0] us);
		longint e, dt, raw, lo, hi, a, d, cmd;
		command_t c;
		e = longint'(err);
		dt = (us == 0) ? 1 : longint'(us);
		integ = clip_acc(integ + round_div(clip_mul(e, dt), 1000000));
		raw = clip_acc(round_div(clip_mul(e - last_err, 1000000), dt));
		if (ki != 0) begin
			lo = clip_acc(round_div(imin * Q_ONE, ki));
			hi = clip_acc(round_div(imax * Q_ONE, ki));
			// The low bound wins when the bounds are crossed.
			if (integ < lo) begin
				integ = lo;
			end else if (integ > hi) begin
				integ = hi;
			end
		end
		a = alpha_w > Q_ONE ? Q_ONE : alpha_w;
		d = round_div(clip_mul(raw, a) + clip_mul(last_deriv, Q_ONE - a), Q_ONE);
		cmd = round_div(clip_mul(e, kp) + clip_mul(integ, ki) + clip_mul(d, kd), Q_ONE);
		c.clip = 1'b0;
		if (cmd > Q_ONE) begin
			cmd = Q_ONE;
			c.clip = 1'b1;
		end else if (cmd < -Q_ONE) begin
			cmd = -Q_ONE;
			c.clip = 1'b1;
		end
		c.drv = cmd[pidaw_pkg::OUT_W-1:0];
		last_err = e;
		last_deriv = d;
		pending_cmds.push_back(c);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			pidaw_pkg::REG_GAIN_P: kp = longint'(val[30:0]);
			pidaw_pkg::REG_GAIN_I: ki = longint'(val[30:0]);
			pidaw_pkg::REG_GAIN_D: kd = longint'(val[30:0]);
			pidaw_pkg::REG_INT_MIN: imin = longint'(signed'(val));
			pidaw_pkg::REG_INT_MAX: imax = longint'(signed'(val));
			pidaw_pkg::REG_ALPHA: alpha_w = longint'(val[16:0]);
			default: ;
		endcase
	endtask

	task automatic send_item(input logic signed [pidaw_pkg::DATA_W-1:0] err,
			input logic [pidaw_pkg::DT_W-1:0] us);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		error_in <= err;
		elapsed_us <= us;
		do @(posedge clk); while (in_stall);
		predict_command(err, us);
	endtask

	// Drop valid and let every outstanding command drain before touching registers.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_error();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'sh8000_0000;
			2: return 32'sh7fff_ffff;
			default: return 32'(signed'($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	function automatic logic [23:0] rand_elapsed();
		case ($urandom_range(0, 7))
			0: return 24'($urandom);
			1: return 24'd0;
			2: return 24'hff_ffff;
			default: return 24'($urandom_range(1, 5000));
		endcase
	endfunction

	task automatic test_directed;
		send_item(32'sd0, 24'd0);
		send_item(32'sh7fff_ffff, 24'd0);
		send_item(32'sh8000_0000, 24'd0);
		send_item(32'sh7fff_ffff, 24'hff_ffff);
		send_item(32'sh7fff_ffff, 24'hff_ffff);
		send_item(32'sh8000_0000, 24'hff_ffff);
		send_item(32'sd65536, 24'd1000);
		send_item(-32'sd65536, 24'd1);
		send_item(32'sd1, 24'd1);
		send_item(-32'sd1, 24'd3);
		send_item(32'sd32768, 24'd2);
		drain();
		// Integral gain of zero removes the integral clamp.
		write_reg(pidaw_pkg::REG_GAIN_I, 32'd0);
		write_reg(pidaw_pkg::REG_ALPHA, 32'h1_ffff);
		send_item(32'sh7fff_ffff, 24'hff_ffff);
		send_item(32'sh7fff_ffff, 24'hff_ffff);
		send_item(-32'sd1000, 24'd7);
		drain();
		// Crossed bounds, alpha of zero and spare register addresses.
		write_reg(pidaw_pkg::REG_GAIN_I, 32'hffff_ffff);
		write_reg(pidaw_pkg::REG_INT_MIN, 32'sd1000);
		write_reg(pidaw_pkg::REG_INT_MAX, -32'sd1000);
		write_reg(pidaw_pkg::REG_ALPHA, 32'd0);
		write_reg(REG_SPARE_LO, 32'hdead_beef);
		write_reg(REG_SPARE_HI, 32'h1234_5678);
		send_item(32'sd5000, 24'd100);
		send_item(-32'sd5000, 24'd100);
		send_item(32'sh8000_0000, 24'hff_ffff);
		drain();
	endtask

	task automatic test_settings;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) begin
				write_reg(pidaw_pkg::REG_GAIN_P, 32'hffff_ffff);
				write_reg(pidaw_pkg::REG_GAIN_D, 32'hffff_ffff);
				write_reg(pidaw_pkg::REG_INT_MIN, 32'h8000_0000);
				write_reg(pidaw_pkg::REG_INT_MAX, 32'h7fff_ffff);
				write_reg(pidaw_pkg::REG_ALPHA, 32'd65536);
			end else begin
				write_reg(pidaw_pkg::REG_GAIN_P, $urandom_range(0, 200000));
				write_reg(pidaw_pkg::REG_GAIN_I, ph == 1 ? 32'd0 : $urandom_range(0, 100000));
				write_reg(pidaw_pkg::REG_GAIN_D, $urandom_range(0, 20000));
				write_reg(pidaw_pkg::REG_INT_MIN, -$urandom_range(0, 70000));
				write_reg(pidaw_pkg::REG_INT_MAX, $urandom_range(0, 70000));
				write_reg(pidaw_pkg::REG_ALPHA, $urandom_range(0, 65536));
			end
			for (int n = 0; n < 190; n++) send_item(rand_error(), rand_elapsed());
			drain();
		end
	endtask

	task automatic test_backpressure;
		write_reg(pidaw_pkg::REG_GAIN_P, 32'd15073);
		write_reg(pidaw_pkg::REG_GAIN_I, 32'd1966);
		long_hold = 1'b1;
		for (int n = 0; n < 40; n++) send_item(rand_error(), rand_elapsed());
		drain();
	endtask

	// Receiver: a random hold before each item, or one long hold when asked.
	initial begin
		int w;
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				w = 3000;
			end else begin
				w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			end
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		command_t exp_c;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected result drive=%0d clamped=%0b", $time, drive,
					drive_clamped);
				fail_count++;
			end else begin
				exp_c = pending_cmds.pop_front();
				if (drive !== exp_c.drv) begin
					$display("%0t: drive expected %0d actual %0d", $time, exp_c.drv, drive);
					fail_count++;
				end
				if (drive_clamped !== exp_c.clip) begin
					$display("%0t: drive_clamped expected %0b actual %0b", $time, exp_c.clip,
						drive_clamped);
					fail_count++;
				end
			end
		end
	end

	initial begin
		kp = 15073;
		ki = 1966;
		kd = 1311;
		imin = -3277;
		imax = 3277;
		alpha_w = 65536;
		last_err = 0;
		integ = 0;
		last_deriv = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_settings();
		test_backpressure();
		repeat (600) @(posedge clk);
		if (fail_count == 0 && pending_cmds.size() == 0) begin
			$display("pid_with_antiwindup_filtered_d regression: pass");
		end else begin
			$display("pid_with_antiwindup_filtered_d regression: fail");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("pid_with_antiwindup_filtered_d regression: fail");
		$finish;
	end

endmodule
